// ===== rtl/core/arcb_pkg.sv =====
// shared constants, types and step functions of the arcball sphere vector pipeline
package arcb_pkg;

    // field widths
    localparam int POS_W         = 14;
    localparam int CFG_W         = 14;
    localparam int CFG_IDX_W     = 1;
    localparam int VEC_W         = 16;
    localparam int VZ_W          = 15;
    localparam int FRAC_BITS_DEF = 15;

    // internal widths, fixed by the field widths
    localparam int NX_W      = 16;
    localparam int MAG_W     = 15;
    localparam int AX_W      = 29;
    localparam int WH_W      = 28;
    localparam int AX2_W     = 58;
    localparam int WH2_W     = 56;
    localparam int S2_W      = 59;
    localparam int RAD_W     = 62;
    localparam int ROOT_W    = 31;
    localparam int REM_W     = 33;
    localparam int NRM_STEPS = 5;
    localparam int SQ_STEPS  = 31;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 14'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 14'd480;

    // saturation limits
    localparam logic [VEC_W-1:0] VEC_POS_MAX = 16'h7fff;
    localparam logic [VEC_W-1:0] VEC_NEG_MAX = 16'h8000;
    localparam logic [VZ_W-1:0]  VZ_MAX      = 15'h7fff;

    // point data carried through the front half of the pipeline
    typedef struct packed {
        logic              outside;
        logic              nx_neg;
        logic              ny_neg;
        logic [MAG_W-1:0]  mag_nx;
        logic [MAG_W-1:0]  mag_ny;
        logic [CFG_W-1:0]  w;
        logic [CFG_W-1:0]  h;
        logic [ROOT_W-1:0] axs;
        logic [ROOT_W-1:0] ays;
    } item_t;

    // flags carried through the back half
    typedef struct packed {
        logic outside;
        logic x_neg;
        logic y_neg;
    } sign_t;

    // square root partial state
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_state_t;

    // divider step result
    typedef struct packed {
        logic              qbit;
        logic [ROOT_W-1:0] rem;
    } div_res_t;

    // one digit of a restoring square root: bring down two radicand bits
    function automatic sq_state_t sq_step(input sq_state_t cur, input logic [1:0] pair);
        sq_state_t        nxt;
        logic [REM_W-1:0] acc;
        logic [REM_W-1:0] trial;
        acc   = {cur.rem[REM_W-3:0], pair};
        trial = {cur.root, 2'b01};
        if (acc >= trial)
        begin
            nxt.rem  = acc - trial;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = acc;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // one bit of a restoring divide, num below twice den
    function automatic div_res_t div_step(input logic [ROOT_W:0] num,
                                          input logic [ROOT_W-1:0] den);
        div_res_t        res;
        logic [ROOT_W:0] diff;
        diff     = num - {1'b0, den};
        res.qbit = (num >= {1'b0, den});
        res.rem  = res.qbit ? diff[ROOT_W-1:0] : num[ROOT_W-1:0];
        return res;
    endfunction

endpackage

// ===== rtl/core/arcball_sphere_vector.sv =====
// arcball mapping of a pointer position onto a unit ball, fully pipelined
//
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  point in  | start, busy         | x_pos, y_pos
//  vector out| done (strobe)       | vec_x, vec_y, vec_z, off_sphere
//  config    | cfg_write           | cfg_index, cfg_data
//
//  one point per clock (Q1.15 at the default FRAC_BITS). the depth is set by the
//  31-step root of the outside length, the bit-per-stage dividers and the
//  bit-per-stage root for z.
//  reset is asynchronous; busy is high in reset and up to the first clock edge after it.
//  results cannot be stalled: each transaction is shown for one cycle on done.
module arcball_sphere_vector #(
    parameter int FRAC_BITS = arcb_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [arcb_pkg::POS_W-1:0]   x_pos,
    input  logic signed [arcb_pkg::POS_W-1:0]   y_pos,
    input  logic                                cfg_write,
    input  logic [arcb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [arcb_pkg::CFG_W-1:0]          cfg_data,
    output logic                                done,
    output logic signed [arcb_pkg::VEC_W-1:0]   vec_x,
    output logic signed [arcb_pkg::VEC_W-1:0]   vec_y,
    output logic [arcb_pkg::VZ_W-1:0]           vec_z,
    output logic                                off_sphere
);
    import arcb_pkg::*;

    localparam int DIV_STEPS = FRAC_BITS + 2;
    localparam int QW        = FRAC_BITS + 2;
    localparam int MW        = FRAC_BITS + 1;
    localparam int Z_STEPS   = FRAC_BITS + 1;
    localparam int ZRW       = 2 * Z_STEPS;
    localparam int SQ2_W     = 2 * MW;
    localparam int R2_W      = 2 * MW + 1;
    localparam int PIPE_LEN  = 4 + NRM_STEPS + SQ_STEPS + DIV_STEPS + 3 + Z_STEPS + 1;
    localparam logic [R2_W-1:0] ONE_SQ = R2_W'(1) << (2 * FRAC_BITS);

    // configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // busy and valid bits
    logic                busy_reg;
    logic                busy_next;
    logic [PIPE_LEN-1:0] vld_reg;
    logic [PIPE_LEN-1:0] vld_next;
    logic                accept;

    assign accept    = start && !busy_reg;
    assign busy_next = 1'b0;
    assign vld_next  = {vld_reg[PIPE_LEN-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            vld_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            vld_reg  <= vld_next;
        end
    end

    // pipeline payload registers
    logic signed [POS_W-1:0] e_x_reg, e_y_reg;
    logic [CFG_W-1:0]        e_w_reg, e_h_reg;

    item_t             m1_item_reg, m1_item_next;
    logic [WH_W-1:0]   m1_wh_reg, m1_wh_next;
    item_t             m2_item_reg, m2_item_next;
    logic [AX2_W-1:0]  m2_ax2_reg, m2_ax2_next, m2_ay2_reg, m2_ay2_next;
    logic [WH2_W-1:0]  m2_wh2_reg, m2_wh2_next;
    item_t             m3_item_reg, m3_item_next;
    logic [RAD_W-1:0]  m3_t_reg, m3_t_next;

    item_t             n_item_reg  [NRM_STEPS];
    item_t             n_item_next [NRM_STEPS];
    logic [RAD_W-1:0]  n_t_reg     [NRM_STEPS];
    logic [RAD_W-1:0]  n_t_next    [NRM_STEPS];

    item_t             q_item_reg  [SQ_STEPS];
    item_t             q_item_next [SQ_STEPS];
    logic [RAD_W-1:0]  q_t_reg     [SQ_STEPS];
    logic [RAD_W-1:0]  q_t_next    [SQ_STEPS];
    sq_state_t         q_sq_reg    [SQ_STEPS];
    sq_state_t         q_sq_next   [SQ_STEPS];

    sign_t             d_sg_reg     [DIV_STEPS];
    sign_t             d_sg_next    [DIV_STEPS];
    logic [ROOT_W-1:0] d_den_x_reg  [DIV_STEPS];
    logic [ROOT_W-1:0] d_den_x_next [DIV_STEPS];
    logic [ROOT_W-1:0] d_den_y_reg  [DIV_STEPS];
    logic [ROOT_W-1:0] d_den_y_next [DIV_STEPS];
    logic [ROOT_W-1:0] d_rem_x_reg  [DIV_STEPS];
    logic [ROOT_W-1:0] d_rem_x_next [DIV_STEPS];
    logic [ROOT_W-1:0] d_rem_y_reg  [DIV_STEPS];
    logic [ROOT_W-1:0] d_rem_y_next [DIV_STEPS];
    logic [QW-1:0]     d_q_x_reg    [DIV_STEPS];
    logic [QW-1:0]     d_q_x_next   [DIV_STEPS];
    logic [QW-1:0]     d_q_y_reg    [DIV_STEPS];
    logic [QW-1:0]     d_q_y_next   [DIV_STEPS];

    sign_t             r_sg_reg, r_sg_next;
    logic [MW-1:0]     r_mx_reg, r_mx_next, r_my_reg, r_my_next;
    sign_t             p_sg_reg, p_sg_next;
    logic [MW-1:0]     p_mx_reg, p_mx_next, p_my_reg, p_my_next;
    logic [SQ2_W-1:0]  p_mx2_reg, p_mx2_next, p_my2_reg, p_my2_next;
    sign_t             c_sg_reg, c_sg_next;
    logic [MW-1:0]     c_mx_reg, c_mx_next, c_my_reg, c_my_next;
    logic [ZRW-1:0]    c_rad_reg, c_rad_next;

    sign_t             z_sg_reg   [Z_STEPS];
    sign_t             z_sg_next  [Z_STEPS];
    logic [MW-1:0]     z_mx_reg   [Z_STEPS];
    logic [MW-1:0]     z_mx_next  [Z_STEPS];
    logic [MW-1:0]     z_my_reg   [Z_STEPS];
    logic [MW-1:0]     z_my_next  [Z_STEPS];
    logic [ZRW-1:0]    z_rad_reg  [Z_STEPS];
    logic [ZRW-1:0]    z_rad_next [Z_STEPS];
    sq_state_t         z_sq_reg   [Z_STEPS];
    sq_state_t         z_sq_next  [Z_STEPS];

    logic [VEC_W-1:0]  vec_x_reg, vec_x_next, vec_y_reg, vec_y_next;
    logic [VZ_W-1:0]   vec_z_reg, vec_z_next;
    logic              off_reg, off_next;

    // centered coordinates and first products
    always_comb
    begin
        logic signed [NX_W-1:0] nx;
        logic signed [NX_W-1:0] ny;
        nx = $signed({e_x_reg[POS_W-1], e_x_reg, 1'b0}) - $signed({2'b00, e_w_reg});
        ny = $signed({2'b00, e_h_reg}) - $signed({e_y_reg[POS_W-1], e_y_reg, 1'b0});
        m1_item_next         = '0;
        m1_item_next.nx_neg  = nx[NX_W-1];
        m1_item_next.ny_neg  = ny[NX_W-1];
        m1_item_next.mag_nx  = nx[NX_W-1] ? MAG_W'(-nx) : nx[MAG_W-1:0];
        m1_item_next.mag_ny  = ny[NX_W-1] ? MAG_W'(-ny) : ny[MAG_W-1:0];
        m1_item_next.w       = e_w_reg;
        m1_item_next.h       = e_h_reg;
        m1_item_next.axs     = ROOT_W'(AX_W'(m1_item_next.mag_nx) * AX_W'(e_h_reg));
        m1_item_next.ays     = ROOT_W'(AX_W'(m1_item_next.mag_ny) * AX_W'(e_w_reg));
        m1_wh_next           = WH_W'(e_w_reg) * WH_W'(e_h_reg);
    end

    // squares for the inside test
    always_comb
    begin
        m2_item_next = m1_item_reg;
        m2_ax2_next  = AX2_W'(m1_item_reg.axs[AX_W-1:0]) * AX2_W'(m1_item_reg.axs[AX_W-1:0]);
        m2_ay2_next  = AX2_W'(m1_item_reg.ays[AX_W-1:0]) * AX2_W'(m1_item_reg.ays[AX_W-1:0]);
        m2_wh2_next  = WH2_W'(m1_wh_reg) * WH2_W'(m1_wh_reg);
    end

    // inside test on exact integers
    always_comb
    begin
        logic [S2_W-1:0] s2;
        s2                   = S2_W'(m2_ax2_reg) + S2_W'(m2_ay2_reg);
        m3_item_next         = m2_item_reg;
        m3_item_next.outside = (s2 > S2_W'(m2_wh2_reg));
        m3_t_next            = RAD_W'(s2);
    end

    // normalize the squared length into the top two bits; the components shift by 16, 8, 4, 2, 1
    always_comb
    begin
        item_t            cur;
        logic [RAD_W-1:0] t;
        int               k;
        for (int i = 0; i < NRM_STEPS; i++)
        begin
            if (i == 0)
            begin
                cur = m3_item_reg;
                t   = m3_t_reg;
            end
            else
            begin
                cur = n_item_reg[i-1];
                t   = n_t_reg[i-1];
            end
            k = 1 << (NRM_STEPS - 1 - i);
            if ((t >> (RAD_W - 2 * k)) == '0)
            begin
                t       = t << (2 * k);
                cur.axs = cur.axs << k;
                cur.ays = cur.ays << k;
            end
            n_item_next[i] = cur;
            n_t_next[i]    = t;
        end
    end

    // length of the outside vector, one root bit per stage
    always_comb
    begin
        item_t            cur;
        logic [RAD_W-1:0] t;
        sq_state_t        sq;
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            if (i == 0)
            begin
                cur = n_item_reg[NRM_STEPS-1];
                t   = n_t_reg[NRM_STEPS-1];
                sq  = '0;
            end
            else
            begin
                cur = q_item_reg[i-1];
                t   = q_t_reg[i-1];
                sq  = q_sq_reg[i-1];
            end
            q_sq_next[i]   = sq_step(sq, t[RAD_W-1:RAD_W-2]);
            q_t_next[i]    = t << 2;
            q_item_next[i] = cur;
        end
    end

    // two restoring dividers, one quotient bit per stage, with a spare bit for rounding
    always_comb
    begin
        item_t             cur;
        sign_t             sg;
        logic [ROOT_W-1:0] dx, dy;
        logic [ROOT_W:0]   numx, numy;
        logic [QW-1:0]     qx, qy;
        div_res_t          rx, ry;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            cur = q_item_reg[SQ_STEPS-1];
            if (i == 0)
            begin
                sg.outside = cur.outside;
                sg.x_neg   = cur.nx_neg;
                sg.y_neg   = cur.ny_neg;
                dx   = cur.outside ? q_sq_reg[SQ_STEPS-1].root : ROOT_W'(cur.w);
                dy   = cur.outside ? q_sq_reg[SQ_STEPS-1].root : ROOT_W'(cur.h);
                numx = {1'b0, cur.outside ? cur.axs : ROOT_W'(cur.mag_nx)};
                numy = {1'b0, cur.outside ? cur.ays : ROOT_W'(cur.mag_ny)};
                qx   = '0;
                qy   = '0;
            end
            else
            begin
                sg   = d_sg_reg[i-1];
                dx   = d_den_x_reg[i-1];
                dy   = d_den_y_reg[i-1];
                numx = {d_rem_x_reg[i-1], 1'b0};
                numy = {d_rem_y_reg[i-1], 1'b0};
                qx   = d_q_x_reg[i-1];
                qy   = d_q_y_reg[i-1];
            end
            rx              = div_step(numx, dx);
            ry              = div_step(numy, dy);
            d_sg_next[i]    = sg;
            d_den_x_next[i] = dx;
            d_den_y_next[i] = dy;
            d_rem_x_next[i] = rx.rem;
            d_rem_y_next[i] = ry.rem;
            d_q_x_next[i]   = {qx[QW-2:0], rx.qbit};
            d_q_y_next[i]   = {qy[QW-2:0], ry.qbit};
        end
    end

    // round to nearest, ties away from zero
    always_comb
    begin
        logic [QW-1:0] sx, sy;
        sx        = d_q_x_reg[DIV_STEPS-1] + QW'(1);
        sy        = d_q_y_reg[DIV_STEPS-1] + QW'(1);
        r_sg_next = d_sg_reg[DIV_STEPS-1];
        r_mx_next = sx[QW-1:1];
        r_my_next = sy[QW-1:1];
    end

    // squares of the rounded components
    always_comb
    begin
        p_sg_next  = r_sg_reg;
        p_mx_next  = r_mx_reg;
        p_my_next  = r_my_reg;
        p_mx2_next = SQ2_W'(r_mx_reg) * SQ2_W'(r_mx_reg);
        p_my2_next = SQ2_W'(r_my_reg) * SQ2_W'(r_my_reg);
    end

    // radicand for z, zero when the rounded point lies past the rim
    always_comb
    begin
        logic [R2_W-1:0] r2;
        logic [R2_W-1:0] diff;
        r2         = R2_W'(p_mx2_reg) + R2_W'(p_my2_reg);
        diff       = ONE_SQ - r2;
        c_sg_next  = p_sg_reg;
        c_mx_next  = p_mx_reg;
        c_my_next  = p_my_reg;
        c_rad_next = (r2 <= ONE_SQ) ? diff[ZRW-1:0] : '0;
    end

    // z root, one bit per stage
    always_comb
    begin
        sign_t          sg;
        logic [MW-1:0]  mx, my;
        logic [ZRW-1:0] rad;
        sq_state_t      sq;
        for (int i = 0; i < Z_STEPS; i++)
        begin
            if (i == 0)
            begin
                sg  = c_sg_reg;
                mx  = c_mx_reg;
                my  = c_my_reg;
                rad = c_rad_reg;
                sq  = '0;
            end
            else
            begin
                sg  = z_sg_reg[i-1];
                mx  = z_mx_reg[i-1];
                my  = z_my_reg[i-1];
                rad = z_rad_reg[i-1];
                sq  = z_sq_reg[i-1];
            end
            z_sq_next[i]  = sq_step(sq, rad[ZRW-1:ZRW-2]);
            z_rad_next[i] = rad << 2;
            z_sg_next[i]  = sg;
            z_mx_next[i]  = mx;
            z_my_next[i]  = my;
        end
    end

    // sign and saturation
    always_comb
    begin
        logic [31:0] mx32, my32, rz32;
        sign_t       sg;
        sg   = z_sg_reg[Z_STEPS-1];
        mx32 = 32'(z_mx_reg[Z_STEPS-1]);
        my32 = 32'(z_my_reg[Z_STEPS-1]);
        rz32 = 32'(z_sq_reg[Z_STEPS-1].root);
        if (sg.x_neg)
            vec_x_next = (mx32 > 32'd32768) ? VEC_NEG_MAX : VEC_W'(32'd0 - mx32);
        else
            vec_x_next = (mx32 > 32'd32767) ? VEC_POS_MAX : mx32[VEC_W-1:0];
        if (sg.y_neg)
            vec_y_next = (my32 > 32'd32768) ? VEC_NEG_MAX : VEC_W'(32'd0 - my32);
        else
            vec_y_next = (my32 > 32'd32767) ? VEC_POS_MAX : my32[VEC_W-1:0];
        if (sg.outside)
            vec_z_next = '0;
        else
            vec_z_next = (rz32 > 32'd32767) ? VZ_MAX : rz32[VZ_W-1:0];
        off_next = sg.outside;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        e_x_reg     <= x_pos;
        e_y_reg     <= y_pos;
        e_w_reg     <= (width_reg == '0) ? CFG_W'(1) : width_reg;
        e_h_reg     <= (height_reg == '0) ? CFG_W'(1) : height_reg;
        m1_item_reg <= m1_item_next;
        m1_wh_reg   <= m1_wh_next;
        m2_item_reg <= m2_item_next;
        m2_ax2_reg  <= m2_ax2_next;
        m2_ay2_reg  <= m2_ay2_next;
        m2_wh2_reg  <= m2_wh2_next;
        m3_item_reg <= m3_item_next;
        m3_t_reg    <= m3_t_next;
        for (int i = 0; i < NRM_STEPS; i++)
        begin
            n_item_reg[i] <= n_item_next[i];
            n_t_reg[i]    <= n_t_next[i];
        end
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            q_item_reg[i] <= q_item_next[i];
            q_t_reg[i]    <= q_t_next[i];
            q_sq_reg[i]   <= q_sq_next[i];
        end
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            d_sg_reg[i]    <= d_sg_next[i];
            d_den_x_reg[i] <= d_den_x_next[i];
            d_den_y_reg[i] <= d_den_y_next[i];
            d_rem_x_reg[i] <= d_rem_x_next[i];
            d_rem_y_reg[i] <= d_rem_y_next[i];
            d_q_x_reg[i]   <= d_q_x_next[i];
            d_q_y_reg[i]   <= d_q_y_next[i];
        end
        r_sg_reg  <= r_sg_next;
        r_mx_reg  <= r_mx_next;
        r_my_reg  <= r_my_next;
        p_sg_reg  <= p_sg_next;
        p_mx_reg  <= p_mx_next;
        p_my_reg  <= p_my_next;
        p_mx2_reg <= p_mx2_next;
        p_my2_reg <= p_my2_next;
        c_sg_reg  <= c_sg_next;
        c_mx_reg  <= c_mx_next;
        c_my_reg  <= c_my_next;
        c_rad_reg <= c_rad_next;
        for (int i = 0; i < Z_STEPS; i++)
        begin
            z_sg_reg[i]  <= z_sg_next[i];
            z_mx_reg[i]  <= z_mx_next[i];
            z_my_reg[i]  <= z_my_next[i];
            z_rad_reg[i] <= z_rad_next[i];
            z_sq_reg[i]  <= z_sq_next[i];
        end
        vec_x_reg <= vec_x_next;
        vec_y_reg <= vec_y_next;
        vec_z_reg <= vec_z_next;
        off_reg   <= off_next;
    end

    // outputs
    assign busy       = busy_reg;
    assign done       = vld_reg[PIPE_LEN-1];
    assign vec_x      = vec_x_reg;
    assign vec_y      = vec_y_reg;
    assign vec_z      = vec_z_reg;
    assign off_sphere = off_reg;

    // every accepted transaction comes out after the fixed depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##PIPE_LEN done)
        else $error("accepted point did not come out after the pipeline depth");

    // a point off the ball has no z
    a_off_no_z: assert property (@(posedge clk) disable iff (!rst_n)
        done && off_sphere |-> vec_z == '0)
        else $error("off-ball result with nonzero z");

    // a normalized vector cannot be all zero
    a_off_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && off_sphere |-> (vec_x != '0 || vec_y != '0))
        else $error("normalized result is the zero vector");

endmodule
